// ----- rtl/bacs_pkg.sv -----
// ----------------------------------------------------------------------------
// bacs_pkg
// Shared types, codes and the divider step for the blit area set-up block.
// ----------------------------------------------------------------------------
package bacs_pkg;

    // output coordinate range, signed
    localparam int COORD_BITS = 16;
    // internal coordinate width, wide enough for every intermediate value
    localparam int CW         = 20;
    // divider: numerator is a 16 x 15 product, quotient is known to fit 15 bits
    localparam int NUM_W      = 31;
    localparam int DEN_W      = 16;
    localparam int QUO_W      = 15;
    localparam int DIV_STEP   = 3;
    localparam int DIV_STAGES = QUO_W / DIV_STEP;

    typedef logic signed [CW-1:0] t_coord;

    typedef enum logic [1:0] {
        ST_REJECT = 2'd0,
        ST_COPY   = 2'd1,
        ST_SCALED = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        KIND_SRC  = 2'd0,
        KIND_DST  = 2'd1,
        KIND_CLIP = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        REG_DEST_W   = 3'd0,
        REG_DEST_H   = 3'd1,
        REG_CLIP_EN  = 3'd2,
        REG_CLIP_L   = 3'd3,
        REG_CLIP_T   = 3'd4,
        REG_CLIP_W   = 3'd5,
        REG_CLIP_H   = 3'd6
    } t_cfg_reg;

    // one axis of a request in flight
    typedef struct packed {
        t_coord sp;
        t_coord ss;
        t_coord dp;
        t_coord ds;
        t_coord cp;
        t_coord cs;
        t_coord smax;
        logic   trim;
    } t_axis;

    typedef struct packed {
        logic  ok;
        logic  same;
        t_axis ax;
        t_axis ay;
    } t_pipe;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } t_div;

    // DIV_STEP restoring steps, quotient bits top down to top-DIV_STEP+1
    function automatic t_div f_div_step(t_div a, logic [DEN_W-1:0] den, int top);
        t_div         r;
        logic [NUM_W:0] sh;
        r = a;
        for (int j = 0; j < DIV_STEP; j++) begin
            sh = (NUM_W+1)'(den) << (top - j);
            if ({1'b0, r.rem} >= sh) begin
                r.rem = NUM_W'({1'b0, r.rem} - sh);
                r.quo[top - j] = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/bacs_div.sv -----
// ----------------------------------------------------------------------------
// bacs_div
// Pipelined unsigned restoring divider, x and y lanes side by side,
// DIV_STEP quotient bits per stage, request state carried alongside.
// ----------------------------------------------------------------------------
module bacs_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  bacs_pkg::t_pipe               i_pay,
    input  logic [bacs_pkg::NUM_W-1:0]    i_num_x,
    input  logic [bacs_pkg::NUM_W-1:0]    i_num_y,
    input  logic [bacs_pkg::DEN_W-1:0]    i_den_x,
    input  logic [bacs_pkg::DEN_W-1:0]    i_den_y,
    output logic                          o_valid,
    output bacs_pkg::t_pipe               o_pay,
    output logic [bacs_pkg::QUO_W-1:0]    o_quo_x,
    output logic [bacs_pkg::QUO_W-1:0]    o_quo_y
);
    localparam int NS = bacs_pkg::DIV_STAGES;

    logic                       r_vld   [NS];
    bacs_pkg::t_pipe            r_pay   [NS];
    bacs_pkg::t_div             r_x     [NS];
    bacs_pkg::t_div             r_y     [NS];
    logic [bacs_pkg::DEN_W-1:0] r_den_x [NS];
    logic [bacs_pkg::DEN_W-1:0] r_den_y [NS];

    for (genvar g = 0; g < NS; g++) begin : g_stage
        logic                       w_vld;
        bacs_pkg::t_pipe            w_pay;
        bacs_pkg::t_div             w_x;
        bacs_pkg::t_div             w_y;
        logic [bacs_pkg::DEN_W-1:0] w_den_x;
        logic [bacs_pkg::DEN_W-1:0] w_den_y;

        if (g == 0) begin : g_first
            assign w_vld   = i_valid;
            assign w_pay   = i_pay;
            assign w_x     = '{rem: i_num_x, quo: '0};
            assign w_y     = '{rem: i_num_y, quo: '0};
            assign w_den_x = i_den_x;
            assign w_den_y = i_den_y;
        end else begin : g_next
            assign w_vld   = r_vld[g-1];
            assign w_pay   = r_pay[g-1];
            assign w_x     = r_x[g-1];
            assign w_y     = r_y[g-1];
            assign w_den_x = r_den_x[g-1];
            assign w_den_y = r_den_y[g-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_pay[g]   <= w_pay;
            r_den_x[g] <= w_den_x;
            r_den_y[g] <= w_den_y;
            r_x[g] <= bacs_pkg::f_div_step(w_x, w_den_x,
                          bacs_pkg::QUO_W - 1 - g * bacs_pkg::DIV_STEP);
            r_y[g] <= bacs_pkg::f_div_step(w_y, w_den_y,
                          bacs_pkg::QUO_W - 1 - g * bacs_pkg::DIV_STEP);
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_pay   = r_pay[NS-1];
    assign o_quo_x = r_x[NS-1].quo;
    assign o_quo_y = r_y[NS-1].quo;

endmodule

// ----- rtl/blit_area_clip_setup.sv -----
// ----------------------------------------------------------------------------
// blit_area_clip_setup
// Clips one blit request against the surface and clip window, trims source
// overhang and rescales the destination, then emits the adjusted rectangles.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high
// after each accepted request until r_acc_hist has cleared, so requests are
// spaced to leave the result port time for its three beats.
// A request passes stages 1 and 2, the first divider, stages 3 and 4, the
// second divider, stages 5 and 6 and the output register; the two pipelined
// 15-bit dividers (five stages each) make up most of that path.
// A rejected request gives one beat with last set; an accepted one gives the
// source, destination and clip rectangles on consecutive cycles. Beats
// cannot be held off. Configuration writes are always taken (ready is tied
// high) and must only be made while no request is in flight.
module blit_area_clip_setup (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_src_x,
    input  logic signed [15:0] i_src_y,
    input  logic signed [15:0] i_src_w,
    input  logic signed [15:0] i_src_h,
    input  logic signed [15:0] i_dst_x,
    input  logic signed [15:0] i_dst_y,
    input  logic signed [15:0] i_dst_w,
    input  logic signed [15:0] i_dst_h,
    input  logic [14:0]        i_src_image_width,
    input  logic [14:0]        i_src_image_height,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_strobe,
    output logic [1:0]         o_status,
    output logic [1:0]         o_rect_kind,
    output logic signed [15:0] o_rect_x,
    output logic signed [15:0] o_rect_y,
    output logic signed [15:0] o_rect_w,
    output logic signed [15:0] o_rect_h,
    output logic               o_last
);
    localparam int SW = 34;
    localparam logic signed [SW-1:0] SAT_HI =
        (SW'(1) <<< (bacs_pkg::COORD_BITS - 1)) - SW'(1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    typedef bacs_pkg::t_coord t_coord;

    // configuration
    logic [14:0]        r_dest_w, r_dest_h;
    logic               r_clip_en;
    logic signed [15:0] r_clip_l, r_clip_t, r_clip_w, r_clip_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest_w  <= '0;
            r_dest_h  <= '0;
            r_clip_en <= 1'b0;
            r_clip_l  <= '0;
            r_clip_t  <= '0;
            r_clip_w  <= '0;
            r_clip_h  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bacs_pkg::REG_DEST_W:  r_dest_w  <= i_cfg_data[14:0];
                bacs_pkg::REG_DEST_H:  r_dest_h  <= i_cfg_data[14:0];
                bacs_pkg::REG_CLIP_EN: r_clip_en <= i_cfg_data[0];
                bacs_pkg::REG_CLIP_L:  r_clip_l  <= i_cfg_data;
                bacs_pkg::REG_CLIP_T:  r_clip_t  <= i_cfg_data;
                bacs_pkg::REG_CLIP_W:  r_clip_w  <= i_cfg_data;
                bacs_pkg::REG_CLIP_H:  r_clip_h  <= i_cfg_data;
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    t_coord w_dmx, w_dmy;
    assign w_dmx = t_coord'(r_dest_w);
    assign w_dmy = t_coord'(r_dest_h);

    // accept spacing
    logic       w_acc;
    logic [1:0] r_acc_hist;
    assign w_acc = start && !busy;
    assign busy  = |r_acc_hist;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_hist <= '0;
        end else begin
            r_acc_hist <= {r_acc_hist[0], w_acc};
        end
    end

    // ---------------- helpers ----------------
    function automatic logic f_meet(t_coord p, t_coord w, t_coord mx);
        return (p < mx) && (t_coord'(0) < p + w);
    endfunction

    function automatic bacs_pkg::t_axis f_entry(t_coord sp, t_coord ss, t_coord dp,
            t_coord ds, t_coord smax, t_coord dmax, logic en, t_coord cl, t_coord cwid);
        bacs_pkg::t_axis a;
        a.sp = sp; a.ss = ss; a.dp = dp; a.ds = ds; a.smax = smax; a.trim = 1'b0;
        if (en) begin
            a.cp = cl;
            a.cs = cwid;
            if (a.cp < 0) begin
                a.cs = a.cs + a.cp;
                a.cp = '0;
            end
            if (a.cp + a.cs > dmax) a.cs = dmax - a.cp;
        end else begin
            a.cp = '0;
            a.cs = dmax;
        end
        return a;
    endfunction

    function automatic bacs_pkg::t_axis f_narrow(bacs_pkg::t_axis a, t_coord size);
        bacs_pkg::t_axis r;
        t_coord dd, lim;
        r  = a;
        dd = r.cp - r.dp;
        if (dd < 0) begin
            r.cs = r.cs + dd;
            r.cp = r.dp;
        end
        lim = size + r.dp - r.cp;
        if (r.cs > lim) r.cs = lim;
        return r;
    endfunction

    function automatic logic [bacs_pkg::NUM_W-1:0] f_num1(bacs_pkg::t_axis a);
        logic [15:0] mag;
        mag = 16'(-a.sp);
        if (a.sp < 0) return bacs_pkg::NUM_W'(mag) * bacs_pkg::NUM_W'(a.ds[14:0]);
        return '0;
    endfunction

    function automatic bacs_pkg::t_axis f_trim_src(bacs_pkg::t_axis a,
            logic [bacs_pkg::QUO_W-1:0] q);
        bacs_pkg::t_axis r;
        r = a;
        if (r.sp < 0) begin
            r.dp = r.dp + t_coord'(q);
            r.ds = r.ds - t_coord'(q);
            r.ss = r.ss + r.sp;
            r.sp = '0;
        end
        r.trim = (r.sp + r.ss > r.smax);
        return r;
    endfunction

    function automatic logic [bacs_pkg::NUM_W-1:0] f_num2(bacs_pkg::t_axis a);
        t_coord span;
        span = a.smax - a.sp;
        if (a.trim) return bacs_pkg::NUM_W'(a.ds[14:0]) * bacs_pkg::NUM_W'(span[14:0]);
        return '0;
    endfunction

    function automatic bacs_pkg::t_axis f_trim_end(bacs_pkg::t_axis a,
            logic [bacs_pkg::QUO_W-1:0] q);
        bacs_pkg::t_axis r;
        r = a;
        if (r.trim) begin
            r.ds = t_coord'(q);
            r.ss = r.smax - r.sp;
        end
        if (r.cp < 0) begin
            r.cs = r.cs + r.cp;
            r.cp = '0;
        end
        return r;
    endfunction

    function automatic logic [15:0] f_sat(t_coord v);
        logic signed [SW-1:0] e;
        e = SW'(v);
        if (e > SAT_HI) e = SAT_HI;
        if (e < SAT_LO) e = SAT_LO;
        return e[15:0];
    endfunction

    // ---------------- stage 1: checks, clip clamp ----------------
    logic            r_v1;
    bacs_pkg::t_pipe r_p1, n_p1;

    always_comb begin
        n_p1.ax = f_entry(t_coord'(i_src_x), t_coord'(i_src_w), t_coord'(i_dst_x),
                          t_coord'(i_dst_w), t_coord'(i_src_image_width), w_dmx,
                          r_clip_en, t_coord'(r_clip_l), t_coord'(r_clip_w));
        n_p1.ay = f_entry(t_coord'(i_src_y), t_coord'(i_src_h), t_coord'(i_dst_y),
                          t_coord'(i_dst_h), t_coord'(i_src_image_height), w_dmy,
                          r_clip_en, t_coord'(r_clip_t), t_coord'(r_clip_h));
        n_p1.same = 1'b0;
        n_p1.ok = (i_dst_w > 0) && (i_dst_h > 0)
                  && f_meet(n_p1.ax.dp, n_p1.ax.ds, w_dmx)
                  && f_meet(n_p1.ay.dp, n_p1.ay.ds, w_dmy)
                  && (i_src_w > 0) && (i_src_h > 0)
                  && f_meet(n_p1.ax.sp, n_p1.ax.ss, n_p1.ax.smax)
                  && f_meet(n_p1.ay.sp, n_p1.ay.ss, n_p1.ay.smax)
                  && (n_p1.ax.cs > 0) && (n_p1.ay.cs > 0);
    end

    // ---------------- stage 2: clip to destination, first product ----------------
    logic                       r_v2;
    bacs_pkg::t_pipe            r_p2, n_p2;
    logic [bacs_pkg::NUM_W-1:0] r_n1x, r_n1y;

    always_comb begin
        n_p2    = r_p1;
        n_p2.ax = f_narrow(r_p1.ax, r_p1.ax.ds);
        n_p2.ay = f_narrow(r_p1.ay, r_p1.ay.ds);
        n_p2.ok = r_p1.ok && (n_p2.ax.cs > 0) && (n_p2.ay.cs > 0);
    end

    // first divider: source left/top overhang
    logic                       w_v3d;
    bacs_pkg::t_pipe            w_p3d;
    logic [bacs_pkg::QUO_W-1:0] w_q1x, w_q1y;

    bacs_div u_div_lead (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v2),
        .i_pay   (r_p2),
        .i_num_x (r_n1x),
        .i_num_y (r_n1y),
        .i_den_x (r_p2.ax.ss[bacs_pkg::DEN_W-1:0]),
        .i_den_y (r_p2.ay.ss[bacs_pkg::DEN_W-1:0]),
        .o_valid (w_v3d),
        .o_pay   (w_p3d),
        .o_quo_x (w_q1x),
        .o_quo_y (w_q1y)
    );

    // ---------------- stage 3: apply leading trim ----------------
    logic            r_v3;
    bacs_pkg::t_pipe r_p3, n_p3;

    always_comb begin
        n_p3    = w_p3d;
        n_p3.ax = f_trim_src(w_p3d.ax, w_q1x);
        n_p3.ay = f_trim_src(w_p3d.ay, w_q1y);
        n_p3.ok = w_p3d.ok && (n_p3.ax.sp < n_p3.ax.smax) && (n_p3.ay.sp < n_p3.ay.smax);
    end

    // ---------------- stage 4: second product ----------------
    logic                       r_v4;
    bacs_pkg::t_pipe            r_p4;
    logic [bacs_pkg::NUM_W-1:0] r_n2x, r_n2y;

    logic                       w_v5d;
    bacs_pkg::t_pipe            w_p5d;
    logic [bacs_pkg::QUO_W-1:0] w_q2x, w_q2y;

    bacs_div u_div_tail (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v4),
        .i_pay   (r_p4),
        .i_num_x (r_n2x),
        .i_num_y (r_n2y),
        .i_den_x (r_p4.ax.ss[bacs_pkg::DEN_W-1:0]),
        .i_den_y (r_p4.ay.ss[bacs_pkg::DEN_W-1:0]),
        .o_valid (w_v5d),
        .o_pay   (w_p5d),
        .o_quo_x (w_q2x),
        .o_quo_y (w_q2y)
    );

    // ---------------- stage 5: trailing trim, clip checks ----------------
    logic            r_v5;
    bacs_pkg::t_pipe r_p5, n_p5;

    always_comb begin
        n_p5    = w_p5d;
        n_p5.ax = f_trim_end(w_p5d.ax, w_q2x);
        n_p5.ay = f_trim_end(w_p5d.ay, w_q2y);
        n_p5.ok = w_p5d.ok
                  && (n_p5.ax.ds > 0) && (n_p5.ax.ss > 0)
                  && (n_p5.ay.ds > 0) && (n_p5.ay.ss > 0)
                  && (n_p5.ax.cs > 0) && (n_p5.ay.cs > 0)
                  && (n_p5.ax.cp < w_dmx) && (n_p5.ay.cp < w_dmy);
    end

    // ---------------- stage 6: clip to surface from new origin ----------------
    logic            r_v6;
    bacs_pkg::t_pipe r_p6, n_p6;

    always_comb begin
        n_p6      = r_p5;
        n_p6.ax   = f_narrow(r_p5.ax, w_dmx);
        n_p6.ay   = f_narrow(r_p5.ay, w_dmy);
        n_p6.ok   = r_p5.ok && (n_p6.ax.cs > 0) && (n_p6.ay.cs > 0);
        n_p6.same = (r_p5.ax.ds == r_p5.ax.ss) && (r_p5.ay.ds == r_p5.ay.ss);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v1 <= w_acc;
            r_v2 <= r_v1;
            r_v3 <= w_v3d;
            r_v4 <= r_v3;
            r_v5 <= w_v5d;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1  <= n_p1;
        r_p2  <= n_p2;
        r_n1x <= f_num1(r_p1.ax);
        r_n1y <= f_num1(r_p1.ay);
        r_p3  <= n_p3;
        r_p4  <= r_p3;
        r_n2x <= f_num2(r_p3.ax);
        r_n2y <= f_num2(r_p3.ay);
        r_p5  <= n_p5;
        r_p6  <= n_p6;
    end

    // ---------------- result beats ----------------
    logic [1:0]         r_left;
    bacs_pkg::t_pipe    r_hold;
    logic               r_o_stb, n_o_stb;
    logic               r_o_last, n_o_last;
    bacs_pkg::t_status  r_o_status, n_o_status;
    bacs_pkg::t_kind    r_o_kind, n_o_kind;
    logic [15:0]        r_o_x, r_o_y, r_o_w, r_o_h;
    logic [15:0]        n_o_x, n_o_y, n_o_w, n_o_h;
    logic [1:0]         n_left;
    bacs_pkg::t_status  w_hold_st;

    assign w_hold_st = r_hold.same ? bacs_pkg::ST_COPY : bacs_pkg::ST_SCALED;

    always_comb begin
        n_left     = r_left;
        n_o_stb    = 1'b0;
        n_o_last   = 1'b0;
        n_o_status = bacs_pkg::ST_REJECT;
        n_o_kind   = bacs_pkg::KIND_SRC;
        n_o_x      = '0;
        n_o_y      = '0;
        n_o_w      = '0;
        n_o_h      = '0;
        if (r_v6) begin
            n_o_stb = 1'b1;
            if (r_p6.ok) begin
                n_o_status = r_p6.same ? bacs_pkg::ST_COPY : bacs_pkg::ST_SCALED;
                n_o_x      = f_sat(r_p6.ax.sp);
                n_o_y      = f_sat(r_p6.ay.sp);
                n_o_w      = f_sat(r_p6.ax.ss);
                n_o_h      = f_sat(r_p6.ay.ss);
                n_left     = 2'd2;
            end else begin
                n_o_last = 1'b1;
                n_left   = 2'd0;
            end
        end else if (r_left != 2'd0) begin
            n_o_stb    = 1'b1;
            n_o_status = w_hold_st;
            n_left     = r_left - 2'd1;
            if (r_left == 2'd2) begin
                n_o_kind = bacs_pkg::KIND_DST;
                n_o_x    = f_sat(r_hold.ax.dp);
                n_o_y    = f_sat(r_hold.ay.dp);
                n_o_w    = f_sat(r_hold.ax.ds);
                n_o_h    = f_sat(r_hold.ay.ds);
            end else begin
                n_o_kind = bacs_pkg::KIND_CLIP;
                n_o_last = 1'b1;
                n_o_x    = f_sat(r_hold.ax.cp);
                n_o_y    = f_sat(r_hold.ay.cp);
                n_o_w    = f_sat(r_hold.ax.cs);
                n_o_h    = f_sat(r_hold.ay.cs);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_o_stb <= 1'b0;
        end else begin
            r_left  <= n_left;
            r_o_stb <= n_o_stb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v6) r_hold <= r_p6;
        r_o_last   <= n_o_last;
        r_o_status <= n_o_status;
        r_o_kind   <= n_o_kind;
        r_o_x      <= n_o_x;
        r_o_y      <= n_o_y;
        r_o_w      <= n_o_w;
        r_o_h      <= n_o_h;
    end

    assign o_strobe    = r_o_stb;
    assign o_last      = r_o_last;
    assign o_status    = r_o_status;
    assign o_rect_kind = r_o_kind;
    assign o_rect_x    = r_o_x;
    assign o_rect_y    = r_o_y;
    assign o_rect_w    = r_o_w;
    assign o_rect_h    = r_o_h;

endmodule

// ----- rtl/bacs_chk.sv -----
// ----------------------------------------------------------------------------
// bacs_chk
// Port-level checks for the blit area set-up block, bound to the top level.
// ----------------------------------------------------------------------------
module bacs_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic [1:0]  o_status,
    input logic [1:0]  o_rect_kind,
    input logic [15:0] o_rect_x,
    input logic [15:0] o_rect_w,
    input logic        o_last
);
    // busy is raised after a taken request
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after request");

    // beats of one request come back to back
    a_beats_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> o_strobe)
        else $error("gap inside a request's beats");

    // a rejection is a single beat, with last set and zero x and width
    a_reject_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_status == bacs_pkg::ST_REJECT) |->
            o_last && (o_rect_x == 16'd0) && (o_rect_w == 16'd0))
        else $error("malformed rejection beat");

    // the final beat of a drawn request carries the clip rectangle
    a_last_is_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last && (o_status != bacs_pkg::ST_REJECT) |->
            (o_rect_kind == bacs_pkg::KIND_CLIP))
        else $error("final beat is not the clip rectangle");

endmodule

bind blit_area_clip_setup bacs_chk u_bacs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_status    (o_status),
    .o_rect_kind (o_rect_kind),
    .o_rect_x    (o_rect_x),
    .o_rect_w    (o_rect_w),
    .o_last      (o_last)
);
